// ===== hw/rtl/tgcq_pkg.sv =====
// Package for the tile grid collision query unit.
// Holds the item, command and configuration types and the shared codes.
// No dependencies.
package tgcq_pkg;

  localparam int IDX_W       = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SHIFT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOLID_MASK  = 2'd3;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_BOX   = 2'd2;

  localparam logic [2:0] KIND_EMPTY = 3'd0;
  localparam logic [2:0] KIND_GRASS = 3'd1;
  localparam logic [2:0] KIND_WALL  = 3'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         tile_col;
    logic [5:0]         tile_row;
    logic [2:0]         tile_kind;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] found_kind;
  } out_item_t;

  typedef struct packed {
    logic [6:0] grid_width;
    logic [6:0] grid_height;
    logic [4:0] tile_shift;
    logic [7:0] solid_mask;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_POINT,
    CMD_SCAN,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] col0;
    logic [IDX_W-1:0] row0;
    logic [IDX_W-1:0] col1;
    logic [IDX_W-1:0] row1;
    logic [2:0]       kind;
    logic             hit;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PWAIT,
    ST_SCAN,
    ST_DONE
  } back_state_e;

endpackage

// ===== hw/rtl/tgcq_front.sv =====
// Front end: accepts input items, maps world coordinates to tile indices,
// checks them against the grid and turns each query, and each on-grid write, into a queue command.
// Depends on tgcq_pkg.
module tgcq_front import tgcq_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  cfg_t     cfg_i,
  input  logic     busy_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_cmd_o
);

  function automatic logic [31:0] tile_mag(logic [31:0] v, logic [4:0] sh);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return m >> sh;
  endfunction

  function automatic logic signed [32:0] tile_idx(logic neg, logic [31:0] q);
    logic signed [32:0] p;
    p = $signed({1'b0, q});
    return neg ? -p : p;
  endfunction

  logic [31:0] q_x0, q_y0, q_x1, q_y1;
  logic        neg_x0, neg_y0, neg_x1, neg_y1;
  logic        col_ok0, row_ok0, col_ok1, row_ok1;
  logic        wr_ok, box_empty, box_out, accept;

  assign q_x0 = tile_mag(in_item_i.min_x, cfg_i.tile_shift);
  assign q_y0 = tile_mag(in_item_i.min_y, cfg_i.tile_shift);
  assign q_x1 = tile_mag(in_item_i.max_x, cfg_i.tile_shift);
  assign q_y1 = tile_mag(in_item_i.max_y, cfg_i.tile_shift);

  assign neg_x0 = in_item_i.min_x[31] && (q_x0 != '0);
  assign neg_y0 = in_item_i.min_y[31] && (q_y0 != '0);
  assign neg_x1 = in_item_i.max_x[31] && (q_x1 != '0);
  assign neg_y1 = in_item_i.max_y[31] && (q_y1 != '0);

  assign col_ok0 = !neg_x0 && (q_x0 < {25'd0, cfg_i.grid_width}) && (q_x0 < 32'(MAX_COLS));
  assign row_ok0 = !neg_y0 && (q_y0 < {25'd0, cfg_i.grid_height}) && (q_y0 < 32'(MAX_ROWS));
  assign col_ok1 = (q_x1 < {25'd0, cfg_i.grid_width}) && (q_x1 < 32'(MAX_COLS));
  assign row_ok1 = (q_y1 < {25'd0, cfg_i.grid_height}) && (q_y1 < 32'(MAX_ROWS));

  assign wr_ok = ({1'b0, in_item_i.tile_col} < cfg_i.grid_width)
              && (32'(in_item_i.tile_col) < 32'(MAX_COLS))
              && ({1'b0, in_item_i.tile_row} < cfg_i.grid_height)
              && (32'(in_item_i.tile_row) < 32'(MAX_ROWS));

  assign box_empty = (tile_idx(neg_x0, q_x0) > tile_idx(neg_x1, q_x1))
                  || (tile_idx(neg_y0, q_y0) > tile_idx(neg_y1, q_y1));
  assign box_out   = neg_x0 || neg_y0 || !col_ok1 || !row_ok1;

  assign in_stall_o = busy_i || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    q_cmd_o      = '0;
    q_cmd_o.col0 = q_x0[IDX_W-1:0];
    q_cmd_o.row0 = q_y0[IDX_W-1:0];
    q_cmd_o.col1 = q_x1[IDX_W-1:0];
    q_cmd_o.row1 = q_y1[IDX_W-1:0];
    q_push_o     = 1'b0;
    case (in_item_i.op)
      OP_WRITE: begin
        q_cmd_o.cmd  = CMD_WRITE;
        q_cmd_o.col0 = IDX_W'(in_item_i.tile_col);
        q_cmd_o.row0 = IDX_W'(in_item_i.tile_row);
        q_cmd_o.kind = in_item_i.tile_kind;
        q_push_o     = accept && wr_ok;
      end
      OP_POINT: begin
        if (col_ok0 && row_ok0) begin
          q_cmd_o.cmd = CMD_POINT;
        end else begin
          q_cmd_o.cmd  = CMD_RESULT;
          q_cmd_o.hit  = 1'b1;
          q_cmd_o.kind = KIND_WALL;
        end
        q_push_o = accept;
      end
      OP_BOX: begin
        if (box_empty) begin
          q_cmd_o.cmd = CMD_RESULT;
        end else if (box_out) begin
          q_cmd_o.cmd = CMD_RESULT;
          q_cmd_o.hit = 1'b1;
        end else begin
          q_cmd_o.cmd = CMD_SCAN;
        end
        q_cmd_o.kind = KIND_EMPTY;
        q_push_o     = accept;
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tgcq_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on tgcq_pkg.
module tgcq_fifo import tgcq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/tgcq_back.sv =====
// Back end: owns the tile store, runs the clearing pass after reset,
// executes queued commands and holds the result register.
// Depends on tgcq_pkg.
module tgcq_back import tgcq_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  cmd_t      q_cmd_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  output logic      busy_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + IDX_W + 1;

  function automatic logic [AW-1:0] addr_of(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    logic [PW-1:0] full;
    full = PW'(r) * PW'(MAX_COLS) + PW'(c);
    return full[AW-1:0];
  endfunction

  logic [2:0]       mem [DEPTH];
  back_state_e      st_q, st_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [IDX_W-1:0] c0_q, c0_d, c1_q, c1_d, r1_q, r1_d, ic_q, ic_d, ir_q, ir_d;
  logic             last_q, last_d, res_hit_q, res_hit_d;
  logic [2:0]       res_kind_q, res_kind_d, rd_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;
  logic             we, rd_en, out_free, solid, load_out;
  logic [AW-1:0]    waddr, raddr;
  logic [2:0]       wdata;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign solid       = cfg_i.solid_mask[rd_q];
  assign busy_o      = (st_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          case (q_cmd_i.cmd)
            CMD_POINT:  st_d = ST_PWAIT;
            CMD_SCAN:   st_d = ST_SCAN;
            CMD_RESULT: st_d = ST_DONE;
            default:    st_d = ST_IDLE;
          endcase
        end
      end
      ST_PWAIT: st_d = ST_DONE;
      ST_SCAN: begin
        if (solid || last_q) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    we       = 1'b0;
    waddr    = addr_of(q_cmd_i.row0, q_cmd_i.col0);
    wdata    = q_cmd_i.kind;
    rd_en    = 1'b0;
    raddr    = addr_of(q_cmd_i.row0, q_cmd_i.col0);
    load_out = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = KIND_GRASS;
      end
      ST_IDLE: begin
        q_pop_o = !q_empty_i;
        we      = !q_empty_i && (q_cmd_i.cmd == CMD_WRITE);
        rd_en   = !q_empty_i && ((q_cmd_i.cmd == CMD_POINT) || (q_cmd_i.cmd == CMD_SCAN));
      end
      ST_SCAN: begin
        rd_en = !(solid || last_q);
        raddr = addr_of(ir_q, ic_q);
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    clr_d      = clr_q;
    c0_d       = c0_q;
    c1_d       = c1_q;
    r1_d       = r1_q;
    ic_d       = ic_q;
    ir_d       = ir_q;
    last_d     = last_q;
    res_hit_d  = res_hit_q;
    res_kind_d = res_kind_q;
    case (st_q)
      ST_CLEAR: clr_d = clr_q + 1'b1;
      ST_IDLE: begin
        c0_d       = q_cmd_i.col0;
        c1_d       = q_cmd_i.col1;
        r1_d       = q_cmd_i.row1;
        last_d     = (q_cmd_i.col0 == q_cmd_i.col1) && (q_cmd_i.row0 == q_cmd_i.row1);
        res_hit_d  = q_cmd_i.hit;
        res_kind_d = q_cmd_i.kind;
        if (q_cmd_i.col0 == q_cmd_i.col1) begin
          ic_d = q_cmd_i.col0;
          ir_d = last_d ? q_cmd_i.row0 : q_cmd_i.row0 + 1'b1;
        end else begin
          ic_d = q_cmd_i.col0 + 1'b1;
          ir_d = q_cmd_i.row0;
        end
      end
      ST_PWAIT: begin
        res_hit_d  = solid;
        res_kind_d = rd_q;
      end
      ST_SCAN: begin
        res_hit_d  = solid;
        res_kind_d = KIND_EMPTY;
        if (!(solid || last_q)) begin
          last_d = (ic_q == c1_q) && (ir_q == r1_q);
          if (!last_d) begin
            if (ic_q == c1_q) begin
              ic_d = c0_q;
              ir_d = ir_q + 1'b1;
            end else begin
              ic_d = ic_q + 1'b1;
            end
          end
        end
      end
      default: begin
        clr_d = clr_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    if (load_out) begin
      out_valid_d           = 1'b1;
      out_item_d.hit        = res_hit_q;
      out_item_d.found_kind = res_kind_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c0_q       <= c0_d;
    c1_q       <= c1_d;
    r1_q       <= r1_d;
    ic_q       <= ic_d;
    ir_q       <= ir_d;
    last_q     <= last_d;
    res_hit_q  <= res_hit_d;
    res_kind_q <= res_kind_d;
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("Command queue popped while empty.");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLEAR) |-> (!q_pop_o && !out_valid_q))
    else $error("Activity during the clearing pass.");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> ((ic_q <= c1_q) && (ir_q <= r1_q) && (c0_q <= c1_q)))
    else $error("Scan pointer left the box.");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_DONE) && out_free) |=> (out_valid_q && (st_q == ST_IDLE)))
    else $error("Finished result was not loaded.");

endmodule

// ===== hw/rtl/tile_grid_collision_query_unit.sv =====
// Top level of the tile grid collision query unit.
// Holds the configuration registers and connects front end, queue and back end.
// Depends on tgcq_pkg, tgcq_front, tgcq_fifo and tgcq_back.
//
//   Channel  Handshake                Payload
//   input    in_valid_i / in_stall_o  in_item_i (in_item_t)
//   output   out_valid_o / out_stall_i out_item_o (out_item_t)
//   config   cfg_we_i                 cfg_idx_i, cfg_data_i
//
// A tile write is done in the idle state; a point query passes through PWAIT and DONE, an off-grid one only DONE.
// A non-empty box query inside the grid reads the covered tiles one by one from the store's
// single read port in the SCAN state, ending early at the first solid tile.
// After reset a clearing pass fills all MAX_COLS*MAX_ROWS entries of the store with
// grass while in_stall_o is high; configuration writes are taken meanwhile.
// The four-entry queue and the result register let either side stall alone.
module tile_grid_collision_query_unit import tgcq_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_empty, busy;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  cfg_d.grid_width  = cfg_data_i[6:0];
        CFG_GRID_HEIGHT: cfg_d.grid_height = cfg_data_i[6:0];
        CFG_TILE_SHIFT:  cfg_d.tile_shift  = cfg_data_i[4:0];
        CFG_SOLID_MASK:  cfg_d.solid_mask  = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= 7'd64;
      cfg_q.grid_height <= 7'd64;
      cfg_q.tile_shift  <= 5'd16;
      cfg_q.solid_mask  <= 8'd56;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tgcq_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .busy_i    (busy),
    .q_full_i  (q_full),
    .q_push_o  (push),
    .q_cmd_o   (push_cmd)
  );

  tgcq_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .data_o (head_cmd),
    .empty_o(q_empty)
  );

  tgcq_back #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_cmd_i    (head_cmd),
    .q_empty_i  (q_empty),
    .q_pop_o    (pop),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== tb/sv/tgcq_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the tile grid collision query unit testbench.
// Keeps its own tile grid and registers and predicts every query result.
// Depends on tgcq_pkg.
package tgcq_tb_pkg;
  import tgcq_pkg::*;

  localparam int         GRID_COLS = 64;
  localparam int         GRID_ROWS = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class collision_scoreboard;
    logic [2:0]  tiles [GRID_COLS*GRID_ROWS];
    cfg_t        cfg;
    out_item_t   expected_q [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      foreach (tiles[i]) tiles[i] = KIND_GRASS;
      cfg.grid_width  = 7'd64;
      cfg.grid_height = 7'd64;
      cfg.tile_shift  = 5'd16;
      cfg.solid_mask  = 8'd56;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH:  cfg.grid_width  = data[6:0];
        CFG_GRID_HEIGHT: cfg.grid_height = data[6:0];
        CFG_TILE_SHIFT:  cfg.tile_shift  = data[4:0];
        CFG_SOLID_MASK:  cfg.solid_mask  = data;
        default: ;
      endcase
    endfunction

    function int cols();
      return (cfg.grid_width > GRID_COLS) ? GRID_COLS : int'(cfg.grid_width);
    endfunction

    function int rows();
      return (cfg.grid_height > GRID_ROWS) ? GRID_ROWS : int'(cfg.grid_height);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Division by the tile size truncates toward zero on both sides of the origin.
    function longint to_tile(logic [31:0] v);
      logic [31:0] mag;
      if (v[31]) begin
        mag = ~v + 32'd1;
        return -longint'({32'd0, mag} >> cfg.tile_shift);
      end
      return longint'({32'd0, v} >> cfg.tile_shift);
    endfunction

    function bit on_grid(longint c, longint r);
      return c >= 0 && c < cols() && r >= 0 && r < rows();
    endfunction

    function bit box_hits(longint c0, longint r0, longint c1, longint r1);
      if (c1 < c0 || r1 < r0) return 1'b0;
      if (c0 < 0 || r0 < 0 || c1 >= cols() || r1 >= rows()) return 1'b1;
      for (longint r = r0; r <= r1; r++) begin
        for (longint c = c0; c <= c1; c++) begin
          if (cfg.solid_mask[tiles[int'(r * GRID_COLS + c)]]) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t  res;
      longint     c0;
      longint     r0;
      logic [2:0] k;
      res = '0;
      case (it.op)
        OP_WRITE: begin
          if (on_grid(longint'(it.tile_col), longint'(it.tile_row))) begin
            tiles[int'(it.tile_row) * GRID_COLS + int'(it.tile_col)] = it.tile_kind;
          end
        end
        OP_POINT: begin
          c0 = to_tile(it.min_x);
          r0 = to_tile(it.min_y);
          if (on_grid(c0, r0)) begin
            k              = tiles[int'(r0 * GRID_COLS + c0)];
            res.hit        = cfg.solid_mask[k];
            res.found_kind = k;
          end else begin
            res.hit        = 1'b1;
            res.found_kind = KIND_WALL;
          end
          expected_q.push_back(res);
        end
        OP_BOX: begin
          res.hit = box_hits(to_tile(it.min_x), to_tile(it.min_y),
                             to_tile(it.max_x), to_tile(it.max_y));
          expected_q.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%0b kind=%0d",
                 $time, got.hit, got.found_kind);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.hit !== want.hit) begin
        $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.found_kind !== want.found_kind) begin
        $display("%0t: found_kind mismatch, expected %0d, actual %0d",
                 $time, want.found_kind, got.found_kind);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the tile grid collision query unit.
// Drives directed and random items under several register settings, stalls mostly random.
// Depends on tgcq_pkg, tgcq_tb_pkg and tile_grid_collision_query_unit.
module testbench;
  import tgcq_pkg::*;
  import tgcq_tb_pkg::*;

  localparam int     NUM_SETTINGS      = 8;
  localparam int     ITEMS_PER_SETTING = 250;
  localparam int     RANDOM_ITEMS      = NUM_SETTINGS * ITEMS_PER_SETTING;
  localparam int     SETTLE_CYCLES     = 32;
  localparam longint WORLD_MAX         = 64'sh7FFF_FFFF;
  localparam longint WORLD_MIN         = -64'sh8000_0000;
  localparam logic [31:0] ONE          = 32'h0001_0000;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  in_item_t              in_item    = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  collision_scoreboard sb;
  int send_idle_pct = 33;
  int recv_idle_pct = 52;
  int directed_sent = 0;
  int random_sent   = 0;

  tile_grid_collision_query_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_item(input in_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  task automatic write_settings(input logic [6:0] w, input logic [6:0] h,
                                input logic [4:0] sh, input logic [7:0] mask);
    write_register(CFG_GRID_WIDTH, {1'b0, w});
    write_register(CFG_GRID_HEIGHT, {1'b0, h});
    write_register(CFG_TILE_SHIFT, {3'b000, sh});
    write_register(CFG_SOLID_MASK, mask);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it.op        = OP_UNUSED;
    it.tile_col  = 6'($urandom_range(0, 63));
    it.tile_row  = 6'($urandom_range(0, 63));
    it.tile_kind = 3'($urandom_range(0, 7));
    it.min_x     = $urandom;
    it.min_y     = $urandom;
    it.max_x     = $urandom;
    it.max_y     = $urandom;
    return it;
  endfunction

  function automatic in_item_t tile_write(input logic [5:0] col, input logic [5:0] row,
                                          input logic [2:0] kind);
    in_item_t it;
    it           = noise_item();
    it.op        = OP_WRITE;
    it.tile_col  = col;
    it.tile_row  = row;
    it.tile_kind = kind;
    return it;
  endfunction

  function automatic in_item_t point_at(input logic [31:0] x, input logic [31:0] y);
    in_item_t it;
    it       = noise_item();
    it.op    = OP_POINT;
    it.min_x = x;
    it.min_y = y;
    return it;
  endfunction

  function automatic in_item_t box_of(input logic [31:0] x0, input logic [31:0] y0,
                                      input logic [31:0] x1, input logic [31:0] y1);
    in_item_t it;
    it       = noise_item();
    it.op    = OP_BOX;
    it.min_x = x0;
    it.min_y = y0;
    it.max_x = x1;
    it.max_y = y1;
    return it;
  endfunction

  // A world coordinate somewhere inside tile t; small negative values still map to tile 0.
  function automatic logic [31:0] coord_at(input longint t, input logic [4:0] sh);
    longint frac;
    longint v;
    frac = longint'($urandom) & ((longint'(1) << sh) - 1);
    if (t > 0 || (t == 0 && $urandom_range(0, 1) == 0)) v = (t << sh) + frac;
    else if (t == 0) v = -frac;
    else v = -(((-t) << sh) + frac);
    if (v > WORLD_MAX) v = WORLD_MAX;
    if (v < WORLD_MIN) v = WORLD_MIN;
    return v[31:0];
  endfunction

  function automatic longint pick_tile(input int n);
    if (n > 0 && $urandom_range(0, 4) != 0) return longint'($urandom_range(0, n - 1));
    return longint'($urandom_range(0, n + 3)) - 2;
  endfunction

  function automatic int box_span();
    if ($urandom_range(0, 39) == 0) return $urandom_range(0, 63);
    if ($urandom_range(0, 9) == 0) return -int'($urandom_range(1, 3));
    return $urandom_range(0, 5);
  endfunction

  function automatic in_item_t random_item();
    in_item_t   it;
    int         pick;
    int         cols;
    int         rows;
    longint     c0;
    longint     r0;
    logic [4:0] sh;
    it   = noise_item();
    cols = sb.cols();
    rows = sb.rows();
    sh   = sb.cfg.tile_shift;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.op = OP_WRITE;
      if (cols > 0 && rows > 0 && $urandom_range(0, 3) != 0) begin
        it.tile_col = 6'($urandom_range(0, cols - 1));
        it.tile_row = 6'($urandom_range(0, rows - 1));
      end
    end else if (pick < 60) begin
      it.op = OP_POINT;
      if ($urandom_range(0, 7) != 0) begin
        it.min_x = coord_at(pick_tile(cols), sh);
        it.min_y = coord_at(pick_tile(rows), sh);
      end
    end else if (pick < 95) begin
      it.op = OP_BOX;
      if ($urandom_range(0, 9) != 0) begin
        c0       = pick_tile(cols);
        r0       = pick_tile(rows);
        it.min_x = coord_at(c0, sh);
        it.min_y = coord_at(r0, sh);
        it.max_x = coord_at(c0 + box_span(), sh);
        it.max_y = coord_at(r0 + box_span(), sh);
      end
    end
    return it;
  endfunction

  task automatic run_directed();
    in_item_t items [$];
    items.push_back(point_at(32'h0, 32'h0));
    items.push_back(tile_write(6'd0, 6'd0, KIND_WALL));
    items.push_back(point_at(32'h0000_8000, 32'h0000_8000));
    items.push_back(tile_write(6'd63, 6'd63, 3'd7));
    items.push_back(point_at(32'h003F_FFFF, 32'h003F_8000));
    items.push_back(point_at(32'hFFFF_8000, 32'h0));
    items.push_back(point_at(32'hFFFF_0000, 32'h0005_0000));
    items.push_back(point_at(32'h0040_0000, 32'h0));
    items.push_back(point_at(32'h8000_0000, 32'h7FFF_FFFF));
    items.push_back(tile_write(6'd1, 6'd0, KIND_EMPTY));
    items.push_back(point_at(ONE, 32'h0));
    items.push_back(box_of(ONE, ONE, 32'h0002_FFFF, 32'h0002_FFFF));
    items.push_back(box_of(32'h0, 32'h0, 32'h0000_8000, 32'h0000_8000));
    items.push_back(box_of(32'h0003_0000, 32'h0003_0000, ONE, ONE));
    items.push_back(box_of(32'hFFFF_0000, ONE, ONE, ONE));
    items.push_back(box_of(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    items.push_back(tile_write(6'd10, 6'd10, 3'd4));
    items.push_back(box_of(32'h0008_0000, 32'h0008_0000, 32'h000C_0000, 32'h000C_0000));
    items.push_back(tile_write(6'd10, 6'd10, KIND_GRASS));
    items.push_back(box_of(ONE, ONE, 32'h003E_FFFF, 32'h003E_FFFF));
    items.push_back(noise_item());
    items.push_back(tile_write(6'd5, 6'd5, 3'd6));
    items.push_back(point_at(32'h0005_4000, 32'h0005_C000));
    foreach (items[i]) begin
      send_item(items[i]);
      directed_sent++;
    end
  endtask

  task automatic apply_setting(input int p);
    case (p)
      1: write_settings(7'd16, 7'd8, 5'd16, 8'h3A);
      2: write_settings(7'd64, 7'd64, 5'd0, 8'h00);
      3: write_settings(7'd127, 7'd100, 5'd31, 8'hFF);
      4: write_settings(7'd1, 7'd1, 5'd20, 8'h80);
      5: write_settings(7'd0, 7'd5, 5'd8, 8'h55);
      6: write_settings(7'd40, 7'd64, 5'd12, 8'($urandom));
      default: write_settings(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                              5'($urandom_range(10, 20)), 8'($urandom));
    endcase
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p > 0) begin
        drain();
        apply_setting(p);
      end
      repeat (ITEMS_PER_SETTING) begin
        if (random_sent < RANDOM_ITEMS / 3) begin
          send_idle_pct = 33;
          recv_idle_pct = 52;
        end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 52;
          recv_idle_pct = 33;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_item(random_item());
        random_sent++;
      end
    end
    drain();
    $display("Run covered %0d directed and %0d random items under %0d register settings.",
             directed_sent, random_sent, NUM_SETTINGS);
    $display("%0d results were compared, %0d mismatches seen.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results still expected.", sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tgcq_pkg.sv
hw/rtl/tgcq_front.sv
hw/rtl/tgcq_fifo.sv
hw/rtl/tgcq_back.sv
hw/rtl/tile_grid_collision_query_unit.sv
tb/sv/tgcq_tb_pkg.sv
tb/sv/testbench.sv
